// ----- src/gdn_pkg.sv -----
// gdn_pkg: shared types, constants and month tables for the gregorian date neighbours core
// no dependencies; used by every module and interface of the block
`timescale 1ns / 1ps
`default_nettype none

package gdn_pkg;

   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int ORDINAL_W = 9;

   // reciprocal of 25 scaled by 2^17, exact for every 14-bit year
   localparam int RECIP_SHIFT = 17;
   localparam int RECIP_W     = 13;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
   localparam logic [RECIP_W-1:0] RECIP_25 = 13'd5243;
   localparam logic [YEAR_W-1:0]  DIV_25   = 14'd25;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC_LAST = 5'd31;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   typedef struct packed {
      logic                 valid_res;
      logic [DAY_W-1:0]     next_day;
      logic [MONTH_W-1:0]   next_month;
      logic [YEAR_W-1:0]    next_year;
      logic [DAY_W-1:0]     prev_day;
      logic [MONTH_W-1:0]   prev_month;
      logic [YEAR_W-1:0]    prev_year;
      logic [ORDINAL_W-1:0] ordinal_day;
   } result_type;

   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } stage_en_type;

   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] month);
      logic [DAY_W-1:0] len;
      case (month)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [ORDINAL_W-1:0] days_before(input logic leap,
                                                        input logic [MONTH_W-1:0] month);
      logic [ORDINAL_W-1:0] base;
      logic [ORDINAL_W-1:0] adj;
      adj = (leap && month > 4'd2) ? 9'd1 : 9'd0;
      case (month)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      return base + adj;
   endfunction

endpackage

`default_nettype wire

// ----- src/gdn_req_if.sv -----
// gdn_req_if: valid/ready channel carrying one input date word
// depends on gdn_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gdn_req_if;
   logic                         valid;
   logic                         ready;
   logic [gdn_pkg::DAY_W-1:0]    day;
   logic [gdn_pkg::MONTH_W-1:0]  month;
   logic [gdn_pkg::YEAR_W-1:0]   year;

   modport source (output valid, output day, output month, output year, input ready);
   modport sink   (input valid, input day, input month, input year, output ready);
endinterface

`default_nettype wire

// ----- src/gdn_rsp_if.sv -----
// gdn_rsp_if: valid/ready channel carrying one result word
// depends on gdn_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface gdn_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           valid_res;
   logic [gdn_pkg::DAY_W-1:0]      next_day;
   logic [gdn_pkg::MONTH_W-1:0]    next_month;
   logic [gdn_pkg::YEAR_W-1:0]     next_year;
   logic [gdn_pkg::DAY_W-1:0]      prev_day;
   logic [gdn_pkg::MONTH_W-1:0]    prev_month;
   logic [gdn_pkg::YEAR_W-1:0]     prev_year;
   logic [gdn_pkg::ORDINAL_W-1:0]  ordinal_day;

   modport source (output valid, output valid_res, output next_day, output next_month,
                   output next_year, output prev_day, output prev_month, output prev_year,
                   output ordinal_day, input ready);
   modport sink   (input valid, input valid_res, input next_day, input next_month,
                   input next_year, input prev_day, input prev_month, input prev_year,
                   input ordinal_day, output ready);
endinterface

`default_nettype wire

// ----- src/gdn_leap.sv -----
// gdn_leap: stages two and three, leap year test by reciprocal divide by 25
// depends on gdn_pkg
`timescale 1ns / 1ps
`default_nettype none

module gdn_leap (
   input  wire logic                  clock,
   input  wire gdn_pkg::stage_en_type en,
   input  wire gdn_pkg::date_type     date,
   output gdn_pkg::date_type          date_out,
   output logic                       leap_out
);

   logic [gdn_pkg::PROD_W-1:0] prod;
   logic [gdn_pkg::QUOT_W-1:0] quot_in;
   logic [gdn_pkg::QUOT_W-1:0] quot_ff;
   gdn_pkg::date_type          date2_ff;
   logic [gdn_pkg::YEAR_W-1:0] back;
   logic                       div25;
   logic                       leap_in;
   logic                       leap_ff;
   gdn_pkg::date_type          date3_ff;

   // stage two: quotient of year / 25
   assign prod    = {{gdn_pkg::RECIP_W{1'b0}}, date.year}
                  * {{gdn_pkg::YEAR_W{1'b0}}, gdn_pkg::RECIP_25};
   assign quot_in = prod[gdn_pkg::PROD_W-1:gdn_pkg::RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (en.s2) begin
         quot_ff  <= quot_in;
         date2_ff <= date;
      end
   end

   // stage three: divisibility and leap rule
   assign back    = gdn_pkg::YEAR_W'({{(gdn_pkg::YEAR_W-gdn_pkg::QUOT_W){1'b0}}, quot_ff}
                  * gdn_pkg::DIV_25);
   assign div25   = (back == date2_ff.year);
   assign leap_in = div25 ? (date2_ff.year[3:0] == 4'd0) : (date2_ff.year[1:0] == 2'd0);

   always_ff @(posedge clock) begin
      if (en.s3) begin
         leap_ff  <= leap_in;
         date3_ff <= date2_ff;
      end
   end

   assign date_out = date3_ff;
   assign leap_out = leap_ff;

endmodule

`default_nettype wire

// ----- src/gdn_calc.sv -----
// gdn_calc: stage four, validity check, neighbour dates and ordinal day into the output register
// depends on gdn_pkg month tables
`timescale 1ns / 1ps
`default_nettype none

module gdn_calc (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire gdn_pkg::date_type     date,
   input  wire logic                  leap,
   output gdn_pkg::result_type        result
);

   logic [gdn_pkg::DAY_W-1:0]   len;
   logic [gdn_pkg::DAY_W-1:0]   prev_len;
   logic                        ok;
   gdn_pkg::result_type         res_in;
   gdn_pkg::result_type         res_ff;

   assign len      = gdn_pkg::month_len(leap, date.month);
   assign prev_len = gdn_pkg::month_len(leap, date.month - gdn_pkg::MONTH_JAN);
   assign ok       = (date.month >= gdn_pkg::MONTH_JAN) && (date.month <= gdn_pkg::MONTH_DEC)
                  && (date.day != '0) && (date.day <= len);

   always_comb begin
      res_in = '0;
      if (ok) begin
         res_in.valid_res = 1'b1;
         if (date.day < len) begin
            res_in.next_day   = date.day + gdn_pkg::DAY_FIRST;
            res_in.next_month = date.month;
            res_in.next_year  = date.year;
         end else if (date.month != gdn_pkg::MONTH_DEC) begin
            res_in.next_day   = gdn_pkg::DAY_FIRST;
            res_in.next_month = date.month + gdn_pkg::MONTH_JAN;
            res_in.next_year  = date.year;
         end else begin
            res_in.next_day   = gdn_pkg::DAY_FIRST;
            res_in.next_month = gdn_pkg::MONTH_JAN;
            res_in.next_year  = date.year + gdn_pkg::YEAR_W'(1);
         end
         if (date.day > gdn_pkg::DAY_FIRST) begin
            res_in.prev_day   = date.day - gdn_pkg::DAY_FIRST;
            res_in.prev_month = date.month;
            res_in.prev_year  = date.year;
         end else if (date.month != gdn_pkg::MONTH_JAN) begin
            res_in.prev_day   = prev_len;
            res_in.prev_month = date.month - gdn_pkg::MONTH_JAN;
            res_in.prev_year  = date.year;
         end else begin
            res_in.prev_day   = gdn_pkg::DAY_DEC_LAST;
            res_in.prev_month = gdn_pkg::MONTH_DEC;
            res_in.prev_year  = date.year - gdn_pkg::YEAR_W'(1);
         end
         res_in.ordinal_day = gdn_pkg::days_before(leap, date.month)
                            + {{(gdn_pkg::ORDINAL_W-gdn_pkg::DAY_W){1'b0}}, date.day};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

`default_nettype wire

// ----- src/gregorian_date_neighbours_core.sv -----
// Gregorian date neighbours: a four-stage pipeline that checks a date and returns the day after,
// the day before and the day of the year. One date word is accepted every cycle while the result
// channel is not stalled; each word passes through the input register, the multiply by the
// reciprocal of 25, the leap test and the month table stage. A stall on the result channel holds
// the pipeline, filling empty stages first. An invalid date returns valid_res low and all zeros.
// Depends on gdn_pkg, gdn_req_if, gdn_rsp_if, gdn_leap and gdn_calc.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_neighbours_core (
   input  wire logic clock,
   input  wire logic reset,
   gdn_req_if.sink   req_port,
   gdn_rsp_if.source rsp_port
);

   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   logic                  en1;
   gdn_pkg::stage_en_type en;
   gdn_pkg::date_type     date1_ff;
   gdn_pkg::date_type     date3;
   logic                  leap3;
   gdn_pkg::result_type   result;

   assign en.s4 = !v4_ff || rsp_port.ready;
   assign en.s3 = !v3_ff || en.s4;
   assign en.s2 = !v2_ff || en.s3;
   assign en1   = !v1_ff || en.s2;

   assign req_port.ready = en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1)   v1_ff <= req_port.valid;
         if (en.s2) v2_ff <= v1_ff;
         if (en.s3) v3_ff <= v2_ff;
         if (en.s4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         date1_ff.day   <= req_port.day;
         date1_ff.month <= req_port.month;
         date1_ff.year  <= req_port.year;
      end
   end

   gdn_leap u_leap (
      .clock    (clock),
      .en       (en),
      .date     (date1_ff),
      .date_out (date3),
      .leap_out (leap3)
   );

   gdn_calc u_calc (
      .clock  (clock),
      .en     (en.s4),
      .date   (date3),
      .leap   (leap3),
      .result (result)
   );

   assign rsp_port.valid       = v4_ff;
   assign rsp_port.valid_res   = result.valid_res;
   assign rsp_port.next_day    = result.next_day;
   assign rsp_port.next_month  = result.next_month;
   assign rsp_port.next_year   = result.next_year;
   assign rsp_port.prev_day    = result.prev_day;
   assign rsp_port.prev_month  = result.prev_month;
   assign rsp_port.prev_year   = result.prev_year;
   assign rsp_port.ordinal_day = result.ordinal_day;

   // invalid word carries zeros
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && !rsp_port.valid_res) |-> (result == '0))
      else $error("invalid date word with nonzero fields");

   // valid word has nonzero months, days and ordinal day
   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.valid_res) |->
         (rsp_port.next_month != '0 && rsp_port.prev_month != '0
          && rsp_port.next_day != '0 && rsp_port.prev_day != '0
          && rsp_port.ordinal_day != '0))
      else $error("valid date word with zero fields");

   // a stage blocked by the next one keeps its word
   a_stage3_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !en.s4) |=> (v3_ff && $stable(date3) && $stable(leap3)))
      else $error("stage three word lost under stall");

   // a full pipeline never accepts while stalled at the output
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && v2_ff && v3_ff && v4_ff && !rsp_port.ready) |-> !req_port.ready)
      else $error("input taken while pipeline full and stalled");

endmodule

`default_nettype wire

// ----- dv/gregorian_date_neighbours_core_tb.sv -----
// testbench for gregorian_date_neighbours_core: calendar edge dates, random dates, invalid
// words, request gaps and result stalls, checked against a date predictor in this file
// depends on gdn_pkg, gdn_req_if, gdn_rsp_if and the core itself
`timescale 1ns / 1ps

module gregorian_date_neighbours_core_tb;
   import gdn_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 10;
   localparam int YEAR_MAX     = (1 << YEAR_W) - 1;

   logic clock = 1'b0;
   logic reset;

   gdn_req_if req_bus ();
   gdn_rsp_if rsp_bus ();

   gregorian_date_neighbours_core uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   int unsigned common_len    [0:11] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
   int unsigned common_before [0:11] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   result_type expected_dates[$];
   int         fail_count      = 0;
   int         quiet_cycles    = 0;
   int         rsp_hold_cycles = 0;
   bit         req_gaps_on     = 1'b1;
   bit         rsp_stalls_on   = 1'b1;

   function automatic bit is_leap_year(input logic [YEAR_W-1:0] year);
      return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
   endfunction

   function automatic int unsigned days_in_month(input bit leap, input logic [MONTH_W-1:0] month);
      return (leap && month == 4'd2) ? 29 : common_len[month - 1];
   endfunction

   function automatic result_type predict_neighbours(input date_type date);
      result_type  r;
      bit          leap;
      int unsigned len;
      r = '0;
      if (date.month < MONTH_JAN || date.month > MONTH_DEC)
         return r;
      leap = is_leap_year(date.year);
      len  = days_in_month(leap, date.month);
      if (date.day == 0 || date.day > len)
         return r;
      r.valid_res = 1'b1;
      // following date
      if (date.day < len) begin
         r.next_day   = date.day + 1'b1;
         r.next_month = date.month;
         r.next_year  = date.year;
      end else if (date.month != MONTH_DEC) begin
         r.next_day   = DAY_FIRST;
         r.next_month = date.month + 1'b1;
         r.next_year  = date.year;
      end else begin
         r.next_day   = DAY_FIRST;
         r.next_month = MONTH_JAN;
         r.next_year  = date.year + 1'b1;
      end
      // preceding date
      if (date.day > DAY_FIRST) begin
         r.prev_day   = date.day - 1'b1;
         r.prev_month = date.month;
         r.prev_year  = date.year;
      end else if (date.month != MONTH_JAN) begin
         r.prev_month = date.month - 1'b1;
         r.prev_day   = DAY_W'(days_in_month(leap, r.prev_month));
         r.prev_year  = date.year;
      end else begin
         r.prev_day   = DAY_DEC_LAST;
         r.prev_month = MONTH_DEC;
         r.prev_year  = date.year - 1'b1;
      end
      r.ordinal_day = ORDINAL_W'(common_before[date.month - 1]
                      + ((leap && date.month > 4'd2) ? 1 : 0) + date.day);
      return r;
   endfunction

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(10, 40);
   endfunction

   function automatic date_type pick_date();
      date_type d;
      int       pick;
      if ($urandom_range(0, 99) < 20) begin
         d.day   = DAY_W'($urandom);
         d.month = MONTH_W'($urandom);
         d.year  = YEAR_W'($urandom);
         return d;
      end
      d.month = MONTH_W'($urandom_range(MONTH_JAN, MONTH_DEC));
      case ($urandom_range(0, 13))
         0:       d.year = YEAR_W'(0);
         1:       d.year = YEAR_W'(YEAR_MAX);
         2:       d.year = YEAR_W'(1900);
         3:       d.year = YEAR_W'(2000);
         4:       d.year = YEAR_W'(9999);
         5:       d.year = YEAR_W'(4 * $urandom_range(0, YEAR_MAX / 4));
         6:       d.year = YEAR_W'(100 * $urandom_range(0, YEAR_MAX / 100));
         default: d.year = YEAR_W'($urandom_range(0, YEAR_MAX));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 25)
         d.day = DAY_FIRST;
      else if (pick < 50)
         d.day = DAY_W'(days_in_month(is_leap_year(d.year), d.month));
      else
         d.day = DAY_W'($urandom_range(1, days_in_month(is_leap_year(d.year), d.month)));
      return d;
   endfunction

   task automatic send_date(input logic [DAY_W-1:0] day, input logic [MONTH_W-1:0] month,
                            input logic [YEAR_W-1:0] year);
      int       gap;
      date_type d;
      d.day   = day;
      d.month = month;
      d.year  = year;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.day   <= d.day;
      req_bus.month <= d.month;
      req_bus.year  <= d.year;
      do @(posedge clock); while (!req_bus.ready);
      expected_dates.insert(expected_dates.size(), predict_neighbours(d));
   endtask

   task automatic send_random_date();
      date_type d;
      d = pick_date();
      send_date(d.day, d.month, d.year);
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic test_calendar_edges();
      send_date(5'd0, 4'd1, 14'd2024);      // day zero
      send_date(5'd31, 4'd0, 14'd2024);     // month zero
      send_date(5'd1, 4'd13, 14'd2024);
      send_date(5'd31, 4'd15, 14'd16383);
      send_date(5'd31, 4'd4, 14'd2023);     // past end of a 30 day month
      send_date(5'd29, 4'd2, 14'd1900);     // century, not leap
      send_date(5'd29, 4'd2, 14'd2000);     // divisible by 400
      send_date(5'd29, 4'd2, 14'd2024);
      send_date(5'd30, 4'd2, 14'd2024);
      send_date(5'd28, 4'd2, 14'd2023);
      send_date(5'd1, 4'd3, 14'd2024);
      send_date(5'd1, 4'd3, 14'd2023);
      send_date(5'd31, 4'd12, 14'd2024);    // day 366
      send_date(5'd1, 4'd1, 14'd2025);
      send_date(5'd31, 4'd12, 14'd16383);   // next year wraps to zero
      send_date(5'd1, 4'd1, 14'd0);         // previous year wraps to all ones
      send_date(5'd29, 4'd2, 14'd0);        // year zero is leap
      send_date(5'd1, 4'd1, 14'd1);
      send_date(5'd31, 4'd12, 14'd9999);
      send_date(5'd30, 4'd4, 14'd2023);
      send_date(5'd31, 4'd1, 14'd16383);
      send_date(5'd15, 4'd6, 14'd8192);
   endtask

   task automatic test_random_dates(input int count);
      repeat (count) send_random_date();
   endtask

   task automatic test_back_to_back(input int count);
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      repeat (count) send_random_date();
      req_gaps_on   = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   // sink holds off long enough for the pipeline to fill and stall the input
   task automatic test_output_hold_off();
      rsp_hold_cycles = 80;
      req_gaps_on     = 1'b0;
      repeat (30) send_random_date();
      req_gaps_on     = 1'b1;
   endtask

   task automatic test_pause_for_results();
      repeat (15) send_random_date();
      wait_for_results();
      repeat (15) send_random_date();
   endtask

   // result sink
   initial begin : rsp_sink
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_stalls_on ? pick_gap() : 0;
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic check_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_check
      result_type exp_word;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_dates.size() == 0) begin
            $error("result word with no date pending");
            fail_count++;
         end else begin
            exp_word = expected_dates.pop_front();
            check_field("valid_res", exp_word.valid_res, rsp_bus.valid_res);
            check_field("next_day", exp_word.next_day, rsp_bus.next_day);
            check_field("next_month", exp_word.next_month, rsp_bus.next_month);
            check_field("next_year", exp_word.next_year, rsp_bus.next_year);
            check_field("prev_day", exp_word.prev_day, rsp_bus.prev_day);
            check_field("prev_month", exp_word.prev_month, rsp_bus.prev_month);
            check_field("prev_year", exp_word.prev_year, rsp_bus.prev_year);
            check_field("ordinal_day", exp_word.ordinal_day, rsp_bus.ordinal_day);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset         <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.day   <= '0;
      req_bus.month <= '0;
      req_bus.year  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_calendar_edges();
      wait_for_results();
      test_random_dates(300);
      test_back_to_back(80);
      test_output_hold_off();
      test_pause_for_results();
      test_random_dates(200);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/gdn_pkg.sv
src/gdn_req_if.sv
src/gdn_rsp_if.sv
src/gdn_leap.sv
src/gdn_calc.sv
src/gregorian_date_neighbours_core.sv
dv/gregorian_date_neighbours_core_tb.sv
